FILE: rtl/pip_pkg.sv
// Shared types and codes for the point-in-polygon crossing test.
// Used by the top level and pip_walk in rtl/, and by the bench; no dependencies.
`default_nettype none

package pip_pkg;

    localparam logic OP_POINT  = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               last;
    } pip_in_t;

    typedef struct packed {
        logic       inside_res;
        logic       overflow;
        logic [8:0] vertex_total;
    } pip_out_t;

    typedef struct packed {
        logic valid;
        logic odd;
    } pip_res_t;

endpackage

`default_nettype wire

FILE: rtl/point_in_polygon_crossing_test.sv
// Point-in-polygon even-odd crossing test, top level.
// Depends on pip_pkg, pip_ram, pip_walk (and through it pip_mul).
//
// Usage:
//   Input beats (in_valid/in_stall, in_data): opcode 0 loads the test point and
//   empties the vertex store; opcode 1 appends a vertex. A vertex with last set
//   starts the test and yields one output beat (out_valid/out_stall, out_data).
//   Vertices beyond MAX_VERTICES are dropped and reported in out_data.overflow.
//   cfg_we/cfg_data write the band half-width (tolerance) while idle.
// Test walk:
//   Point and plain vertex beats do not raise in_stall.
//   The test walks the vertex memory, reading each vertex once (the closing
//   edge reuses the first vertex), plus one read per backward-search step,
//   and runs the iterative multiplier for two products on an edge that needs
//   the exact intersection compare.
//   in_stall is high while the test runs.
// Reset: point, counts, flags and tolerance clear; memory contents are not.
// A stalled output beat holds; a finished test waits in the walker, with
// in_stall still high, until the output register frees up.
`default_nettype none

module point_in_polygon_crossing_test #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pip_pkg::pip_in_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pip_pkg::pip_out_t  out_data,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_data
);
    import pip_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [CW-1:0]        count_reg;
    logic                 ovf_reg;
    logic signed [CB-1:0] px_reg, py_reg;
    logic [30:0]          tol_reg;
    logic                 ovf_hold_reg;
    logic [8:0]           tot_hold_reg;
    logic                 out_valid_reg;
    pip_out_t             out_data_reg;

    logic                 accept;
    logic                 is_vertex;
    logic                 store_ok;
    logic [CW-1:0]        count_new;
    logic signed [CB-1:0] in_x, in_y;
    logic                 walk_start;
    logic                 walk_busy;
    logic [AW-1:0]        rd_addr;
    logic [2*CB-1:0]      rd_data;
    pip_res_t             walk_res;
    logic                 out_take;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = walk_busy;
    assign is_vertex  = in_data.opcode == OP_VERTEX;
    assign store_ok   = count_reg < CW'(MAX_VERTICES);
    assign count_new  = store_ok ? count_reg + CW'(1) : count_reg;
    assign in_x       = CB'(in_data.x_coord);
    assign in_y       = CB'(in_data.y_coord);
    assign walk_start = accept && is_vertex && in_data.last;
    assign out_take   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    pip_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (accept && is_vertex && store_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_x, in_y}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pip_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .n         (count_new),
        .point_x   (px_reg),
        .point_y   (py_reg),
        .tolerance (tol_reg),
        .rd_data   (rd_data),
        .rd_addr   (rd_addr),
        .busy      (walk_busy),
        .res       (walk_res),
        .res_take  (out_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            tol_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
            if (accept)
            begin
                if (!is_vertex)
                begin
                    px_reg    <= in_x;
                    py_reg    <= in_y;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else if (in_data.last)
                begin
                    tot_hold_reg <= 9'(count_new);
                    ovf_hold_reg <= ovf_reg || !store_ok;
                    count_reg    <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    count_reg <= count_new;
                    ovf_reg   <= ovf_reg || !store_ok;
                end
            end
            if (walk_res.valid && out_take)
            begin
                out_valid_reg             <= 1'b1;
                out_data_reg.inside_res   <= walk_res.odd;
                out_data_reg.overflow     <= ovf_hold_reg;
                out_data_reg.vertex_total <= tot_hold_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/pip_mul.sv
// Iterative signed multiplier, eight multiplier bits per cycle.
// Depends on nothing; used by pip_walk for the exact intersection compare.
`default_nettype none

module pip_mul #(
    parameter int W = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic                  done,
    output logic signed [2*W-1:0] p
);

    localparam int NS = (W + 7) / 8;
    localparam int SW = $clog2(NS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [SW-1:0]         cnt_reg;
    logic [2*W-1:0]        ma_reg;
    logic [W-1:0]          mb_reg;
    logic [2*W-1:0]        acc_reg;
    logic signed [2*W-1:0] p_reg;
    logic [W-1:0]          ua;
    logic [W-1:0]          ub;
    logic [2*W-1:0]        partial;
    logic [2*W-1:0]        sum;

    assign ua      = a[W-1] ? W'(-a) : W'(a);
    assign ub      = b[W-1] ? W'(-b) : W'(b);
    assign partial = ma_reg * (2*W)'(mb_reg[7:0]);
    assign sum     = acc_reg + partial;
    assign done    = done_reg;
    assign p       = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                ma_reg   <= (2*W)'(ua);
                mb_reg   <= ub;
                acc_reg  <= '0;
                neg_reg  <= a[W-1] ^ b[W-1];
            end
            else if (busy_reg)
            begin
                acc_reg <= sum;
                ma_reg  <= ma_reg << 8;
                mb_reg  <= mb_reg >> 8;
                cnt_reg <= cnt_reg + SW'(1);
                if (cnt_reg == SW'(NS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    p_reg    <= neg_reg ? signed'(-sum) : signed'(sum);
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pip_walk.sv
// Edge walk over the vertex memory: band tests, backward search, crossing rule.
// Depends on pip_pkg and pip_mul.
`default_nettype none

module pip_walk #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     n,
    input  logic signed [COORD_BITS-1:0]          point_x,
    input  logic signed [COORD_BITS-1:0]          point_y,
    input  logic [30:0]                           tolerance,
    input  logic [2*COORD_BITS-1:0]               rd_data,
    output logic [$clog2(MAX_VERTICES)-1:0]       rd_addr,
    output logic                                  busy,
    output pip_pkg::pip_res_t                     res,
    input  logic                                  res_take
);
    import pip_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int D  = CB + 1;
    localparam int EW = (CB + 2 > 33) ? CB + 2 : 33;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_FIRSTW, S_NEXT, S_LOAD, S_EVAL,
        S_BACK, S_BACKW, S_MULA, S_MULB, S_DONE
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         n_reg;
    logic [AW-1:0]         i_reg;
    logic [AW-1:0]         k_reg;
    logic [CW-1:0]         steps_reg;
    logic                  odd_reg;
    logic signed [CB-1:0]  first_x_reg, first_y_reg;
    logic signed [CB-1:0]  cur_x_reg, cur_y_reg;
    logic signed [CB-1:0]  nxt_x_reg, nxt_y_reg;
    logic signed [2*D-1:0] lhs_reg;

    logic signed [EW-1:0]  tol_e;
    logic signed [CB-1:0]  rd_x, rd_y;
    logic                  last_edge;
    logic [AW-1:0]         j_idx;
    logic [AW-1:0]         k_start, k_dec;
    logic                  cur_in, nxt_in, nxt_out, px_lt_cx;
    logic signed [CB-1:0]  ymin, ymax, xlow;
    logic                  cr_toggle, cr_mul;
    logic                  back_go, back_flip;
    logic                  mul_start, mul_done, mul_less;
    logic signed [D-1:0]   mul_a, mul_b;
    logic signed [2*D-1:0] mul_p;
    logic                  adv, flip;

    function automatic logic band(input logic signed [CB-1:0] y);
        logic signed [EW-1:0] d;
        d = EW'(point_y) - EW'(y);
        return (d < tol_e) && (d > -tol_e);
    endfunction

    function automatic logic far(input logic signed [CB-1:0] y);
        logic signed [EW-1:0] d;
        d = EW'(point_y) - EW'(y);
        return (d > tol_e) || (d < -tol_e);
    endfunction

    assign tol_e = EW'(tolerance);
    assign rd_x  = rd_data[2*CB-1:CB];
    assign rd_y  = rd_data[CB-1:0];

    assign last_edge = (CW'(i_reg) + CW'(1)) == n_reg;
    assign j_idx     = last_edge ? '0 : i_reg + AW'(1);
    assign k_start   = (i_reg == '0) ? AW'(n_reg - CW'(1)) : i_reg - AW'(1);
    assign k_dec     = (k_reg == '0) ? AW'(n_reg - CW'(1)) : k_reg - AW'(1);

    always_comb
    begin
        case (state_reg)
            S_FIRST: rd_addr = '0;
            S_NEXT:  rd_addr = j_idx;
            S_BACK:  rd_addr = k_reg;
            default: rd_addr = '0;
        endcase
    end

    // edge classification
    always_comb
    begin
        cur_in   = band(cur_y_reg);
        nxt_in   = band(nxt_y_reg);
        nxt_out  = far(nxt_y_reg);
        px_lt_cx = point_x < cur_x_reg;
        if (cur_y_reg < nxt_y_reg)
        begin
            ymin = cur_y_reg;
            ymax = nxt_y_reg;
            xlow = cur_x_reg;
        end
        else
        begin
            ymin = nxt_y_reg;
            ymax = cur_y_reg;
            xlow = nxt_x_reg;
        end
        cr_toggle = 1'b0;
        cr_mul    = 1'b0;
        if (cur_x_reg > point_x && nxt_x_reg > point_x)
        begin
            cr_toggle = 1'b0;
        end
        else if (cur_y_reg == nxt_y_reg)
        begin
            cr_toggle = 1'b0;
        end
        else if (cur_x_reg == nxt_x_reg)
        begin
            cr_toggle = (point_y >= ymin) && (point_y < ymax);
        end
        else if (point_y == ymin && point_x > xlow)
        begin
            cr_toggle = 1'b1;
        end
        else if (point_y > ymax || point_y < ymin)
        begin
            cr_toggle = 1'b0;
        end
        else
        begin
            cr_mul = 1'b1;
        end
    end

    assign back_go   = (steps_reg < n_reg) && band(rd_y);
    assign back_flip = (nxt_y_reg < point_y && rd_y > point_y) ||
                       (nxt_y_reg > point_y && rd_y < point_y);

    // lhs = (px-ix)(iy-jy), rhs = (py-iy)(ix-jx)
    always_comb
    begin
        if (state_reg == S_MULA)
        begin
            mul_a = D'(point_x) - D'(cur_x_reg);
            mul_b = D'(cur_y_reg) - D'(nxt_y_reg);
        end
        else
        begin
            mul_a = D'(point_y) - D'(cur_y_reg);
            mul_b = D'(cur_x_reg) - D'(nxt_x_reg);
        end
    end

    assign mul_start = (state_reg == S_EVAL && !cur_in && !nxt_in && cr_mul) ||
                       (state_reg == S_MULA && mul_done);
    assign mul_less  = (cur_y_reg > nxt_y_reg) ? (lhs_reg < mul_p) : (mul_p < lhs_reg);

    pip_mul #(
        .W (D)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        case (state_reg)
            S_EVAL:
            begin
                adv  = !(cur_in && !px_lt_cx && nxt_out) && !(!cur_in && !nxt_in && cr_mul);
                flip = !cur_in && !nxt_in && cr_toggle;
            end
            S_BACKW:
            begin
                adv  = !back_go;
                flip = !back_go && back_flip;
            end
            S_MULB:
            begin
                adv  = mul_done;
                flip = mul_done && mul_less;
            end
            default:
            begin
                adv  = 1'b0;
                flip = 1'b0;
            end
        endcase
    end

    assign busy       = state_reg != S_IDLE;
    assign res.valid  = state_reg == S_DONE;
    assign res.odd    = odd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            odd_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= n;
                        odd_reg   <= 1'b0;
                        state_reg <= (n == '0) ? S_DONE : S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    state_reg <= S_FIRSTW;
                end
                S_FIRSTW:
                begin
                    first_x_reg <= rd_x;
                    first_y_reg <= rd_y;
                    cur_x_reg   <= rd_x;
                    cur_y_reg   <= rd_y;
                    i_reg       <= '0;
                    state_reg   <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (last_edge)
                    begin
                        nxt_x_reg <= first_x_reg;
                        nxt_y_reg <= first_y_reg;
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    nxt_x_reg <= rd_x;
                    nxt_y_reg <= rd_y;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (cur_in)
                    begin
                        if (!px_lt_cx && nxt_out)
                        begin
                            k_reg     <= k_start;
                            steps_reg <= '0;
                            state_reg <= S_BACK;
                        end
                    end
                    else if (!nxt_in && cr_mul)
                    begin
                        state_reg <= S_MULA;
                    end
                end
                S_BACK:
                begin
                    state_reg <= S_BACKW;
                end
                S_BACKW:
                begin
                    if (back_go)
                    begin
                        k_reg     <= k_dec;
                        steps_reg <= steps_reg + CW'(1);
                        state_reg <= S_BACK;
                    end
                end
                S_MULA:
                begin
                    if (mul_done)
                    begin
                        lhs_reg   <= mul_p;
                        state_reg <= S_MULB;
                    end
                end
                S_MULB:
                begin
                    if (!mul_done)
                    begin
                        state_reg <= S_MULB;
                    end
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (adv)
            begin
                odd_reg <= odd_reg ^ flip;
                if (last_edge)
                begin
                    state_reg <= S_DONE;
                end
                else
                begin
                    cur_x_reg <= nxt_x_reg;
                    cur_y_reg <= nxt_y_reg;
                    i_reg     <= i_reg + AW'(1);
                    state_reg <= S_NEXT;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/pip_checker.sv
// Checker for the point-in-polygon crossing test: watches the input and output
// channels, predicts each result from its own copy of the state, and compares.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  pip_pkg::pip_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  pip_pkg::pip_out_t out_data,
    input  logic              cfg_we,
    input  logic [30:0]       cfg_data,
    output int                fail_count,
    output int                pending_results
);
    import pip_pkg::*;

    localparam int MAX_VERTS = 256;

    longint   test_x;
    longint   test_y;
    longint   band;
    longint   vx [MAX_VERTS];
    longint   vy [MAX_VERTS];
    int       nverts;
    bit       dropped;
    pip_out_t expected_q[$];

    function automatic bit near_line(longint y);
        longint d;
        d = test_y - y;
        return (d < band) && (d > -band);
    endfunction

    function automatic bit edge_hit(longint ix, longint iy, longint jx, longint jy);
        longint ymin, ymax, xlow;
        logic signed [127:0] lhs, rhs;
        if (ix > test_x && jx > test_x) return 0;
        if (iy == jy) return 0;
        if (iy < jy)
        begin
            ymin = iy; ymax = jy; xlow = ix;
        end
        else
        begin
            ymin = jy; ymax = iy; xlow = jx;
        end
        if (ix == jx) return (test_y >= ymin) && (test_y < ymax);
        if (test_y == ymin && test_x > xlow) return 1;
        if (test_y > ymax || test_y < ymin) return 0;
        lhs = 128'(signed'(test_y - iy)) * 128'(signed'(ix - jx));
        rhs = 128'(signed'(test_x - ix)) * 128'(signed'(iy - jy));
        if (iy > jy) return lhs < rhs;
        return rhs < lhs;
    endfunction

    function automatic bit odd_crossings();
        bit     odd;
        int     j, k, steps;
        longint dj, d0, d1;
        odd = 0;
        for (int i = 0; i < nverts; i++)
        begin
            j = (i + 1 == nverts) ? 0 : i + 1;
            if (near_line(vy[i]))
            begin
                if (test_x < vx[i]) continue;
                dj = test_y - vy[j];
                if (dj > band || dj < -band)
                begin
                    k = (i == 0) ? nverts - 1 : i - 1;
                    steps = 0;
                    while (steps < nverts && near_line(vy[k]))
                    begin
                        k = (k == 0) ? nverts - 1 : k - 1;
                        steps++;
                    end
                    d0 = vy[j] - test_y;
                    d1 = vy[k] - test_y;
                    if ((d0 < 0 && d1 > 0) || (d0 > 0 && d1 < 0)) odd = !odd;
                end
            end
            else if (near_line(vy[j]))
                continue;
            else if (edge_hit(vx[i], vy[i], vx[j], vy[j]))
                odd = !odd;
        end
        return odd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pip_out_t e;
        if (!rst_n)
        begin
            test_x = 0; test_y = 0; band = 0; nverts = 0; dropped = 0;
            fail_count = 0;
            expected_q.delete();
            pending_results = 0;
        end
        else
        begin
            if (cfg_we) band = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (in_data.opcode == OP_POINT)
                begin
                    test_x = in_data.x_coord;
                    test_y = in_data.y_coord;
                    nverts = 0;
                    dropped = 0;
                end
                else
                begin
                    if (nverts < MAX_VERTS)
                    begin
                        vx[nverts] = in_data.x_coord;
                        vy[nverts] = in_data.y_coord;
                        nverts++;
                    end
                    else
                        dropped = 1;
                    if (in_data.last)
                    begin
                        e.inside_res = odd_crossings();
                        e.overflow = dropped;
                        e.vertex_total = 9'(nverts);
                        expected_q.push_back(e);
                        nverts = 0;
                        dropped = 0;
                    end
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_data.inside_res !== e.inside_res)
                    begin
                        $error("inside_res expected %0d actual %0d",
                               e.inside_res, out_data.inside_res);
                        fail_count++;
                    end
                    if (out_data.overflow !== e.overflow)
                    begin
                        $error("overflow expected %0d actual %0d",
                               e.overflow, out_data.overflow);
                        fail_count++;
                    end
                    if (out_data.vertex_total !== e.vertex_total)
                    begin
                        $error("vertex_total expected %0d actual %0d",
                               e.vertex_total, out_data.vertex_total);
                        fail_count++;
                    end
                end
            end
            pending_results = expected_q.size();
        end
    end
endmodule

FILE: verif/tb_point_in_polygon_crossing_test.sv
// Top of the crossing-test bench: clock, reset, polygon stimulus with random
// gaps and output stalls, tolerance phases, verdict. Depends on pip_pkg,
// pip_checker and the RTL top.
`timescale 1ns / 1ps

module tb_point_in_polygon_crossing_test;
    import pip_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    pip_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    pip_out_t    out_data;
    logic        cfg_we;
    logic [30:0] cfg_data;
    int          fail_count;
    int          pending_results;
    int          idle_cycles;
    int          burst_left;
    bit          stall_free;
    int          px, py;

    point_in_polygon_crossing_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    pip_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // receiver stall pattern; long free stretches at times
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_free <= !stall_free;
        out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [31:0] x, logic [31:0] y, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= '{opcode: op, x_coord: x, y_coord: y, last: lst};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    task automatic set_band(logic [30:0] v);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] near_coord(int c);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return c;
            2: return c + $urandom_range(0, 4) - 2;
            default: return c + ($urandom_range(0, 8) - 4) * 32'h8000;
        endcase
    endfunction

    task automatic random_polygon(int maxn);
        int n;
        n = $urandom_range(0, 7) == 0 ? $urandom_range(1, maxn) : $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0)
        begin
            px = $urandom_range(0, 3) == 0 ? $urandom : ($urandom_range(0, 8) - 4) * 32'h10000;
            py = $urandom_range(0, 3) == 0 ? $urandom : ($urandom_range(0, 8) - 4) * 32'h10000;
            send_beat(OP_POINT, px, py, $urandom_range(0, 1));
        end
        for (int i = 0; i < n; i++)
            send_beat(OP_VERTEX, near_coord(px), near_coord(py), i == n - 1);
    endtask

    initial
    begin
        rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_data = '0;
        out_stall = 0; stall_free = 0; idle_cycles = 0; burst_left = 0;
        px = 0; py = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: zero tolerance, square around origin, extremes
        send_beat(OP_VERTEX, 32'h0, 32'h0, 1'b1);
        send_beat(OP_POINT, 32'h0, 32'h0, 1'b1);
        send_beat(OP_VERTEX, 32'hFFF0_0000, 32'hFFF0_0000, 1'b0);
        send_beat(OP_VERTEX, 32'h0010_0000, 32'hFFF0_0000, 1'b0);
        send_beat(OP_VERTEX, 32'h0010_0000, 32'h0010_0000, 1'b0);
        send_beat(OP_VERTEX, 32'hFFF0_0000, 32'h0010_0000, 1'b1);
        send_beat(OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_beat(OP_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_beat(OP_VERTEX, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_beat(OP_VERTEX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_beat(OP_POINT, 32'h0, 32'h0, 1'b0);
        send_beat(OP_VERTEX, 32'hFFFF_0000, 32'h0, 1'b0);
        send_beat(OP_VERTEX, 32'h0001_0000, 32'h0002_0000, 1'b0);
        send_beat(OP_VERTEX, 32'h0001_0000, 32'hFFFE_0000, 1'b1);
        drain();
        set_band(31'h0000_8000);
        send_beat(OP_POINT, 32'h0005_0000, 32'h0, 1'b0);
        send_beat(OP_VERTEX, 32'h0, 32'h0000_1000, 1'b0);
        send_beat(OP_VERTEX, 32'h0, 32'h0003_0000, 1'b0);
        send_beat(OP_VERTEX, 32'h0001_0000, 32'hFFFF_F000, 1'b0);
        send_beat(OP_VERTEX, 32'h0002_0000, 32'h0000_0100, 1'b0);
        send_beat(OP_VERTEX, 32'h0002_0000, 32'hFFFD_0000, 1'b1);
        drain();
        // store overflow: 258 vertices, last two dropped
        px = 0; py = 0;
        send_beat(OP_POINT, 32'h0, 32'h0, 1'b0);
        for (int i = 0; i < 258; i++)
            send_beat(OP_VERTEX, near_coord(0), near_coord(0), i == 257);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_band(31'h0);
                1: set_band(31'h7FFF_FFFF);
                2: set_band(31'h0001_0000);
                default: set_band($urandom_range(0, 32'h0004_0000));
            endcase
            for (int p = 0; p < 16; p++) random_polygon(40);
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
